/* rtl/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, register codes and the reciprocal table of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int CH_W      = 8;
	localparam int NUM_CH    = 3;
	localparam int PIX_W     = CH_W * NUM_CH;
	localparam int NUM_TAPS  = 9;
	localparam int SUM_W     = 12;
	localparam int NUM_W     = SUM_W + 1;
	localparam int RECIP_W   = 18;
	localparam int RECIP_SH  = 18;
	localparam int PROD_W    = NUM_W + RECIP_W;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;

	localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_W-1:0] FH_RESET = 13'd768;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic emit;
		logic left_ex;
		logic right_ex;
		logic top_ex;
		logic bot_ex;
		logic last;
	} pos_flags_t;

	// ceil(2^18 / (2*count)); exact for numerators below 2^13
	function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] cnt);
		logic [RECIP_W-1:0] m;
		case (cnt)
			4'd1:    m = 18'd131072;
			4'd2:    m = 18'd65536;
			4'd3:    m = 18'd43691;
			4'd4:    m = 18'd32768;
			4'd6:    m = 18'd21846;
			4'd9:    m = 18'd14564;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

/* rtl/bb3_ram.sv */
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bb3_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/bb3_ctrl.sv */
// ----------------------------------------------------------------------------
// bb3_ctrl
// Config registers and frame position counters; decodes each word into a
// line buffer address and the border flags of the pixel it completes.
// ----------------------------------------------------------------------------
module bb3_ctrl import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	input  logic                  accept,
	input  logic                  drain_req,
	output logic                  take,
	output logic [AW-1:0]         addr,
	output pos_flags_t            flags
);

	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [AW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [PW-1:0]   drain_q;

	logic            cfg_wr;
	logic [PW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic [PW-1:0]   col_x;
	logic [HW-1:0]   row_x;
	logic [PW-1:0]   dm1;
	logic [PW-1:0]   dmin;
	logic [PW-1:0]   ocol;
	logic [HW-1:0]   orow;
	logic            emit;

	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = PW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = PW'(MAX_WIDTH);
		end else begin
			w_eff = PW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height_q);
		end
	end

	assign col_x = PW'(col_q);
	assign row_x = HW'(row_q);
	assign dm1   = drain_q - 1'b1;
	assign dmin  = (dm1 > w_eff) ? w_eff : dm1;

	always_comb begin
		take = 1'b0;
		emit = 1'b0;
		addr = '0;
		orow = '0;
		ocol = '0;
		if (drain_q == '0) begin
			take = !drain_req;
			addr = col_q;
			if (col_q != '0) begin
				emit = (row_x != '0);
				orow = row_x - 1'b1;
				ocol = col_x - 1'b1;
			end else begin
				emit = (32'(row_x) >= 32'd2);
				orow = HW'(32'(row_x) - 32'd2);
				ocol = w_eff - 1'b1;
			end
		end else begin
			take = drain_req;
			if (dmin < w_eff) begin
				addr = AW'(dmin);
			end
			if (dmin == '0) begin
				emit = (32'(h_eff) >= 32'd2);
				orow = HW'(32'(h_eff) - 32'd2);
				ocol = w_eff - 1'b1;
			end else if (dmin < w_eff) begin
				emit = 1'b1;
				orow = h_eff - 1'b1;
				ocol = dmin - 1'b1;
			end else begin
				emit = 1'b1;
				orow = h_eff - 1'b1;
				ocol = w_eff - 1'b1;
			end
		end
	end

	assign flags.emit     = emit;
	assign flags.left_ex  = (ocol == '0);
	assign flags.right_ex = (ocol >= w_eff - 1'b1);
	assign flags.top_ex   = (orow == '0);
	assign flags.bot_ex   = (orow >= h_eff - 1'b1);
	assign flags.last     = (orow == h_eff - 1'b1) && (ocol == w_eff - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
			col_q          <= '0;
			row_q          <= '0;
			drain_q        <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (accept && take) begin
			if (drain_q == '0) begin
				if (col_x + 1'b1 >= w_eff) begin
					col_q <= '0;
					if (row_x + 1'b1 >= h_eff) begin
						row_q   <= '0;
						drain_q <= PW'(1);
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (dmin >= w_eff) begin
				drain_q <= '0;
			end else begin
				drain_q <= dmin + PW'(2);
			end
		end
	end

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_x < w_eff) else $error("column counter beyond frame width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_x < h_eff) else $error("row counter beyond frame height");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q <= w_eff + 1'b1) else $error("drain counter overran the flush");

endmodule

/* rtl/bb3_window.sv */
// ----------------------------------------------------------------------------
// bb3_window
// Line buffer read stage and the 3x3 window. Two RAMs hold the previous two
// rows; a write-to-read bypass covers one-pixel-wide frames.
// ----------------------------------------------------------------------------
module bb3_window import bb3_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [AW-1:0] addr,
	input  pix_t       pix,
	input  pos_flags_t flags,
	input  logic       s3_free,
	output logic       s1_free,
	output logic       s2_v,
	output pos_flags_t flags_s2,
	output pix_t       win [NUM_TAPS]
);

	logic          s1_v;
	logic [AW-1:0] addr_s1;
	pix_t          pix_s1;
	pos_flags_t    flags_s1;
	logic          fwd_s1;
	pix_t          wr_up_q;
	pix_t          wr_mid_q;
	pix_t          up_rd;
	pix_t          mid_rd;
	pix_t          up_eff;
	pix_t          mid_eff;
	pix_t          win_q [NUM_TAPS];
	logic          s2_free;
	logic          s1_adv;

	assign s2_free = !s2_v || s3_free;
	assign s1_free = !s1_v || s2_free;
	assign s1_adv  = s1_v && s2_free;

	bb3_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH), .ADDR_W(AW)) u_upper (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (mid_eff),
		.re    (load),
		.raddr (addr),
		.rdata (up_rd)
	);

	bb3_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH), .ADDR_W(AW)) u_middle (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (load),
		.raddr (addr),
		.rdata (mid_rd)
	);

	assign up_eff  = fwd_s1 ? wr_up_q  : up_rd;
	assign mid_eff = fwd_s1 ? wr_mid_q : mid_rd;

	always_ff @(posedge clk) begin
		if (load) begin
			addr_s1  <= addr;
			pix_s1   <= pix;
			flags_s1 <= flags;
			fwd_s1   <= s1_v && (addr_s1 == addr);
		end
		if (s1_adv) begin
			wr_up_q  <= mid_eff;
			wr_mid_q <= pix_s1;
			flags_s2 <= flags_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			for (int k = 0; k < NUM_TAPS; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (s1_free) begin
				s1_v <= load;
			end
			if (s2_free) begin
				s2_v <= s1_v && flags_s1.emit;
			end
			if (s1_adv) begin
				for (int k = 0; k < 6; k++) begin
					win_q[k] <= win_q[k+3];
				end
				win_q[6] <= up_eff;
				win_q[7] <= mid_eff;
				win_q[8] <= pix_s1;
			end
		end
	end

	assign win = win_q;

	a_window_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v && !s3_free |=> s2_v && $stable(win_q[4]))
		else $error("window moved under a pending result");

endmodule

/* rtl/bb3_mean.sv */
// ----------------------------------------------------------------------------
// bb3_mean
// Masked 3x3 channel sums, then rounded mean by reciprocal multiply into the
// output register.
// ----------------------------------------------------------------------------
module bb3_mean import bb3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s2_v,
	input  pos_flags_t flags_s2,
	input  pix_t       win [NUM_TAPS],
	output logic       s3_free,
	output logic       m_tvalid,
	input  logic       m_tready,
	output pix_t       m_tdata,
	output logic       m_tlast
);

	logic [SUM_W-1:0]  sum [NUM_CH];
	logic [NUM_W-1:0]  num [NUM_CH];
	logic [1:0]        ncol;
	logic [1:0]        nrow;
	logic [3:0]        cnt;
	logic [2:0]        col_on;
	logic [2:0]        row_on;

	logic              s3_v;
	logic [NUM_W-1:0]  num_s3 [NUM_CH];
	logic [3:0]        cnt_s3;
	logic              last_s3;
	logic              out_free;
	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0] prod [NUM_CH];

	assign col_on = {!flags_s2.right_ex, 1'b1, !flags_s2.left_ex};
	assign row_on = {!flags_s2.bot_ex, 1'b1, !flags_s2.top_ex};
	assign ncol   = 2'd3 - 2'(flags_s2.left_ex) - 2'(flags_s2.right_ex);
	assign nrow   = 2'd3 - 2'(flags_s2.top_ex) - 2'(flags_s2.bot_ex);
	assign cnt    = 4'(ncol) * 4'(nrow);

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum[ch] = '0;
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					if (col_on[c] && row_on[r]) begin
						sum[ch] = sum[ch] + SUM_W'(win[c*3+r][ch*CH_W +: CH_W]);
					end
				end
			end
			num[ch] = {sum[ch], 1'b0} + NUM_W'(cnt);
		end
	end

	assign out_free = !m_tvalid || m_tready;
	assign s3_free  = !s3_v || out_free;
	assign recip    = recip_of(cnt_s3);

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod[ch] = PROD_W'(num_s3[ch]) * PROD_W'(recip);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_v && s3_free) begin
			num_s3  <= num;
			cnt_s3  <= cnt;
			last_s3 <= flags_s2.last;
		end
		if (s3_v && out_free) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				m_tdata[ch*CH_W +: CH_W] <= prod[ch][RECIP_SH +: CH_W];
			end
			m_tlast <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s3_free) begin
				s3_v <= s2_v;
			end
			if (out_free) begin
				m_tvalid <= s3_v;
			end
		end
	end

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		s3_v |-> (cnt_s3 == 4'd1 || cnt_s3 == 4'd2 || cnt_s3 == 4'd3 ||
		          cnt_s3 == 4'd4 || cnt_s3 == 4'd6 || cnt_s3 == 4'd9))
		else $error("neighbour count outside the 3x3 set");

endmodule

/* rtl/box_blur_3x3_stream_core.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_core
// Streaming 3x3 box blur of RGB pixels in raster order, borders excluded.
// Throughput: one word per cycle in and out; ready stalls only when the
// four-stage pipe behind it is full and the output is not taken.
// Path: the word that completes a window passes the read, window, sum and output registers;
// in words the result lags the input by frame width + 1, flushed by drain words.
// Reset: counters and window clear at once, frame 1024 x 768; no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_core import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
	input  logic                  s_tuser,   // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out
	output logic                  m_tlast,   // frame_last
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic          accept;
	logic          take;
	logic          load;
	logic [AW-1:0] addr;
	pos_flags_t    flags;
	pix_t          pix;
	logic          s1_free;
	logic          s3_free;
	logic          s2_v;
	pos_flags_t    flags_s2;
	pix_t          win [NUM_TAPS];

	assign pready   = 1'b1;
	assign s_tready = s1_free;
	assign accept   = s_tvalid && s_tready;
	assign load     = accept && take;
	assign pix      = s_tuser ? '0 : s_tdata;

	bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AW(AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.accept    (accept),
		.drain_req (s_tuser),
		.take      (take),
		.addr      (addr),
		.flags     (flags)
	);

	bb3_window #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.addr     (addr),
		.pix      (pix),
		.flags    (flags),
		.s3_free  (s3_free),
		.s1_free  (s1_free),
		.s2_v     (s2_v),
		.flags_s2 (flags_s2),
		.win      (win)
	);

	bb3_mean u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_v     (s2_v),
		.flags_s2 (flags_s2),
		.win      (win),
		.s3_free  (s3_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* tb/box_blur_3x3_stream_core_test.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_core_test
// Self-checking regression for the streaming 3x3 box blur. A cycle-free model
// of the line buffers and window predicts every blurred pixel; each output
// word is checked against the oldest prediction. Frame size registers are set
// over APB and read back between phases. Directed corner frames and size
// clamps come first, then random frames with random source and sink stalls,
// then a stretch at full rate.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bb3_pkg::*;

	localparam int MAX_W  = 1024;
	localparam int MAX_H  = 4096;
	localparam int SETTLE = 16;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} blur_px_t;

	typedef enum int {PX_RANDOM, PX_WHITE, PX_BLACK, PX_EXTREME} px_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [PIX_W-1:0]      m_tdata;
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	box_blur_3x3_stream_core #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	blur_px_t        pending_px[$];
	pix_t            upper_row  [MAX_W];
	pix_t            middle_row [MAX_W];
	pix_t            win_px     [NUM_TAPS];
	int              col_pos;
	int              row_pos;
	int              drain_pos;
	logic [FW_W-1:0] width_reg;
	logic [FH_W-1:0] height_reg;
	int              errors;
	int              taken_words;
	bit              src_idle_on;
	bit              sink_idle_on;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("box_blur_3x3_stream_core regression: fail");
		$finish;
	end

	// ---- model -------------------------------------------------------------

	function automatic int eff_width();
		if (width_reg == '0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg == '0) return 1;
		if (height_reg > MAX_H) return MAX_H;
		return int'(height_reg);
	endfunction

	function automatic void shift_in(input int col, input pix_t px);
		if (col >= MAX_W) col = 0;
		for (int k = 0; k < 6; k++) win_px[k] = win_px[k+3];
		win_px[6] = upper_row[col];
		win_px[7] = middle_row[col];
		win_px[8] = px;
		upper_row[col] = middle_row[col];
		middle_row[col] = px;
	endfunction

	function automatic blur_px_t blur_at(input int orow, input int ocol, input int w, input int h);
		int              c0, c1, r0, r1, n, sum;
		logic [CH_W-1:0] mean [NUM_CH];
		blur_px_t        res;
		c0 = (ocol > 0) ? 0 : 1;
		c1 = (ocol + 1 < w) ? 2 : 1;
		r0 = (orow > 0) ? 0 : 1;
		r1 = (orow + 1 < h) ? 2 : 1;
		n = (c1 - c0 + 1) * (r1 - r0 + 1);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum = 0;
			for (int c = c0; c <= c1; c++)
				for (int r = r0; r <= r1; r++)
					sum += win_px[c*3+r][ch*CH_W +: CH_W];
			mean[ch] = CH_W'((2 * sum + n) / (2 * n));
		end
		res.red   = mean[0];
		res.green = mean[1];
		res.blue  = mean[2];
		res.last  = (orow == h - 1) && (ocol == w - 1);
		return res;
	endfunction

	// update on an accepted input word; queue the blurred pixel it completes
	function automatic void track_word(input logic drain, input pix_t data);
		int w, h, r, c, d, orow, ocol;
		w = eff_width();
		h = eff_height();
		if (!drain) begin
			if (drain_pos != 0) return;
			if (col_pos >= w) col_pos = 0;
			if (row_pos >= h) row_pos = 0;
			r = row_pos;
			c = col_pos;
			shift_in(c, data);
			if (c > 0) begin
				orow = r - 1;
				ocol = c - 1;
			end else begin
				orow = r - 2;
				ocol = w - 1;
			end
			col_pos = c + 1;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos = r + 1;
				if (row_pos >= h) begin
					row_pos = 0;
					drain_pos = 1;
				end
			end
		end else begin
			if (drain_pos == 0) return;
			d = drain_pos - 1;
			if (d > w) d = w;
			shift_in((d < w) ? d : 0, '0);
			if (d == 0) begin
				orow = h - 2;
				ocol = w - 1;
			end else if (d < w) begin
				orow = h - 1;
				ocol = d - 1;
			end else begin
				orow = h - 1;
				ocol = w - 1;
			end
			drain_pos = (d >= w) ? 0 : d + 2;
		end
		taken_words++;
		if (orow >= 0) pending_px.push_back(blur_at(orow, ocol, w, h));
	endfunction

	// ---- output check ------------------------------------------------------

	function automatic void match_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_out
		blur_px_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_px.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected word, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = pending_px.pop_front();
				match_field("red", 32'(want.red), 32'(m_tdata[CH_W-1:0]));
				match_field("green", 32'(want.green), 32'(m_tdata[2*CH_W-1:CH_W]));
				match_field("blue", 32'(want.blue), 32'(m_tdata[3*CH_W-1:2*CH_W]));
				match_field("frame_last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	// sink back-pressure
	initial begin
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// ---- drivers -----------------------------------------------------------

	task automatic send_word(input logic drain, input pix_t data);
		@(negedge clk);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= drain;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		track_word(drain, data);
	endtask

	// stop the source and let every expected word come out
	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic check_reg(input logic idx, input logic [CFG_DATA_W-1:0] want);
		logic [CFG_DATA_W-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== want) begin
			errors++;
			$display("%0t ns: register %0d readback, expected %h, actual %h",
				$time, idx, want, rd);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
		wait_quiet();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
		else height_reg = value[FH_W-1:0];
		col_pos   = 0;
		row_pos   = 0;
		drain_pos = 0;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		check_reg(idx, (idx == REG_FRAME_WIDTH) ? CFG_DATA_W'(width_reg) : CFG_DATA_W'(height_reg));
	endtask

	// raw register values; upper pwdata bits are junk and must be dropped
	task automatic set_frame(input int raw_w, input int raw_h);
		logic [CFG_DATA_W-1:0] value;
		value = $urandom;
		value[FW_W-1:0] = raw_w[FW_W-1:0];
		write_reg(REG_FRAME_WIDTH, value);
		value = $urandom;
		value[FH_W-1:0] = raw_h[FH_W-1:0];
		write_reg(REG_FRAME_HEIGHT, value);
	endtask

	function automatic pix_t pick_pixel(input px_mode_t mode);
		pix_t px;
		case (mode)
			PX_WHITE: px = '1;
			PX_BLACK: px = '0;
			PX_EXTREME: begin
				for (int ch = 0; ch < NUM_CH; ch++)
					px[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: px = PIX_W'($urandom);
		endcase
		return px;
	endfunction

	// one frame of w*h pixels then w+1 drains, or a cut frame with no drains; noise words land where ignored
	task automatic send_frame(input int w, input int h, input px_mode_t mode,
			input bit noisy, input bit partial);
		int npix;
		npix = partial ? $urandom_range(0, w * h - 1) : w * h;
		for (int i = 0; i < npix; i++) begin
			if (noisy && drain_pos == 0 && $urandom_range(0, 15) == 0)
				send_word(1'b1, PIX_W'($urandom));
			if ($urandom_range(0, 299) == 0) wait_quiet();
			send_word(1'b0, pick_pixel(mode));
		end
		if (partial) return;
		for (int i = 0; i <= w; i++) begin
			if (noisy && $urandom_range(0, 7) == 0) send_word(1'b0, PIX_W'($urandom));
			send_word(1'b1, PIX_W'($urandom));
		end
	endtask

	// ---- tests -------------------------------------------------------------

	task automatic test_reset_values();
		check_reg(REG_FRAME_WIDTH, CFG_DATA_W'(FW_RESET));
		check_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(FH_RESET));
	endtask

	task automatic test_corner_frames();
		// 1x1 frame, stray drain before it and stray pixel after it
		set_frame(1, 1);
		send_word(1'b1, '1);
		send_word(1'b0, '1);
		send_word(1'b0, 24'h123456);
		send_word(1'b1, '0);
		send_word(1'b1, '1);
		// zero sizes act as one
		set_frame(0, 0);
		send_word(1'b0, '0);
		send_word(1'b1, '0);
		send_word(1'b1, '0);
		set_frame(3, 2);
		send_frame(3, 2, PX_EXTREME, 1'b0, 1'b0);
		// register write in mid-frame restarts it
		set_frame(2, 2);
		repeat (3) send_word(1'b0, pick_pixel(PX_RANDOM));
		set_frame(2, 2);
		send_frame(2, 2, PX_RANDOM, 1'b0, 1'b0);
	endtask

	// oversized registers: rows wrap at the maximum width, top of a tall frame
	task automatic test_size_clamp();
		set_frame(2047, 2);
		repeat (eff_width() + 8) send_word(1'b0, pick_pixel(PX_RANDOM));
		set_frame(2, 8191);
		repeat (40) send_word(1'b0, pick_pixel(PX_RANDOM));
	endtask

	task automatic test_random_frames(input int quota);
		int       w, h, first, nframes;
		bit       cut;
		px_mode_t mode;
		first = taken_words;
		while (taken_words - first < quota) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: w = $urandom_range(1, 6);
				6, 7, 8:          w = $urandom_range(7, 24);
				default:          w = $urandom_range(25, 64);
			endcase
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			set_frame(w, h);
			nframes = $urandom_range(1, 3);
			for (int f = 0; f < nframes; f++) begin
				mode = ($urandom_range(0, 4) == 0) ? px_mode_t'($urandom_range(1, 3)) : PX_RANDOM;
				cut = ($urandom_range(0, 9) == 0);
				send_frame(w, h, mode, $urandom_range(0, 3) == 0, cut);
				if (cut) break;
			end
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		errors      = 0;
		taken_words = 0;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		for (int i = 0; i < MAX_W; i++) begin
			upper_row[i]  = '0;
			middle_row[i] = '0;
		end
		for (int i = 0; i < NUM_TAPS; i++) win_px[i] = '0;
		col_pos    = 0;
		row_pos    = 0;
		drain_pos  = 0;
		width_reg  = FW_RESET;
		height_reg = FH_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_corner_frames();
		test_size_clamp();
		test_random_frames(450);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		test_random_frames(200);
		wait_quiet();

		if (errors == 0)
			$display("box_blur_3x3_stream_core regression: pass");
		else
			$display("box_blur_3x3_stream_core regression: fail");
		$finish;
	end

endmodule
